>>> src/csched_pkg.sv
`default_nettype none

package csched_pkg;

  localparam int MOTORS_DEF = 4;
  // number of target fields and mask bits on the ports
  localparam int TARGETS    = 4;

  localparam int TICK_W = 20;
  localparam int POS_W  = 16;
  localparam int RATE_W = 16;
  localparam int DIST_W = 16;
  localparam int INT_W  = 32;
  localparam int MASK_W = TARGETS;

  // divider operand widths: tick_rate*maxd over delta*rate
  localparam int NUM_W = TICK_W + DIST_W;
  localparam int DEN_W = DIST_W + RATE_W;

  localparam logic [TICK_W-1:0] TICK_RATE_RST = TICK_W'(1000);

  // word kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

endpackage

`default_nettype wire

>>> src/coordinated_stepper_scheduler.sv
`default_nettype none

// Coordinated stepper scheduler. A tick word (kind 1) moves from S_IDLE
// to S_TICK, where the result is registered once the output register is
// free; ready is high again from the cycle in which that result appears.
// A set-target word (kind 0) first scans the active motors for the
// largest distance, then for each motor in turn either writes the
// interval directly (motor on target or with zero rate) or runs the
// shared 36-step restoring divider, then registers the result in S_FIN.
// The active motor count is min(NUM_MOTORS,4). in_ready is high only
// while the sequencer is idle; a finished result waits in the output
// register and the next word can be taken meanwhile. Motors beyond four
// are not used; unused mask bits read 0.
module coordinated_stepper_scheduler #(
  parameter int NUM_MOTORS = csched_pkg::MOTORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [csched_pkg::TICK_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic signed [csched_pkg::POS_W-1:0] in_target_0,
  input  logic signed [csched_pkg::POS_W-1:0] in_target_1,
  input  logic signed [csched_pkg::POS_W-1:0] in_target_2,
  input  logic signed [csched_pkg::POS_W-1:0] in_target_3,
  input  logic [csched_pkg::RATE_W-1:0]       in_max_rate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csched_pkg::MASK_W-1:0]       out_step_mask,
  output logic [csched_pkg::MASK_W-1:0]       out_dir_mask,
  output logic                                out_done_res
);

  import csched_pkg::*;

  localparam int ACT   = (NUM_MOTORS < TARGETS) ? NUM_MOTORS : TARGETS;
  localparam int IDX_W = (ACT > 1) ? $clog2(ACT) : 1;
  localparam int CNT_W = $clog2(ACT + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ACT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_MUL,
    S_DIVGO,
    S_DIVW,
    S_FIN,
    S_TICK
  } state_t;

  state_t state_r;

  logic [TICK_W-1:0]       tick_rate_r;
  logic signed [POS_W-1:0] pos_r      [ACT];
  logic signed [POS_W-1:0] goal_r     [ACT];
  logic [INT_W-1:0]        interval_r [ACT];
  logic [INT_W-1:0]        elapsed_r  [ACT];

  logic [RATE_W-1:0] rate_r;
  logic [DIST_W-1:0] maxd_r;
  logic [CNT_W-1:0]  m_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;

  logic              out_valid_r;
  logic [MASK_W-1:0] out_step_mask_r;
  logic [MASK_W-1:0] out_dir_mask_r;
  logic              out_done_res_r;

  logic signed [POS_W-1:0] tgt [TARGETS];

  assign tgt[0] = in_target_0;
  assign tgt[1] = in_target_1;
  assign tgt[2] = in_target_2;
  assign tgt[3] = in_target_3;

  // distance of the motor under the sequencer
  logic [IDX_W-1:0]  mi;
  logic [POS_W:0]    dsub;
  logic [POS_W:0]    dabs;
  logic [DIST_W-1:0] dcur;

  assign mi = m_r[IDX_W-1:0];

  always_comb begin
    dsub = {pos_r[mi][POS_W-1], pos_r[mi]} - {goal_r[mi][POS_W-1], goal_r[mi]};
    dabs = dsub[POS_W] ? (~dsub + 1'b1) : dsub;
    dcur = dabs[DIST_W-1:0];
  end

  // masks and per-motor tick lanes
  logic [MASK_W-1:0]       dir_m;
  logic                    done_m;
  logic [MASK_W-1:0]       step_m;
  logic [INT_W-1:0]        el_inc [ACT];
  logic signed [POS_W-1:0] pos_nx [ACT];

  always_comb begin
    dir_m  = '0;
    done_m = 1'b1;
    step_m = '0;
    for (int i = 0; i < ACT; i++) begin
      if (pos_r[i] != goal_r[i]) done_m = 1'b0;
      if (goal_r[i] > pos_r[i]) dir_m[i] = 1'b1;
      el_inc[i] = (elapsed_r[i] == '1) ? elapsed_r[i] : elapsed_r[i] + 1'b1;
      step_m[i] = (pos_r[i] != goal_r[i]) && (el_inc[i] > interval_r[i]);
      pos_nx[i] = dir_m[i] ? pos_r[i] + POS_W'(1) : pos_r[i] - POS_W'(1);
    end
  end

  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic             out_free;
  logic             out_load;

  assign div_start = (state_r == S_DIVGO);
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = ((state_r == S_FIN) || (state_r == S_TICK)) && out_free;

  csched_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (num_r),
    .den_i   (den_r),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_rate_r <= TICK_RATE_RST;
      out_valid_r <= 1'b0;
      m_r         <= '0;
      maxd_r      <= '0;
      for (int i = 0; i < ACT; i++) begin
        pos_r[i]      <= '0;
        goal_r[i]     <= '0;
        interval_r[i] <= '0;
        elapsed_r[i]  <= '1;
      end
    end else begin
      if (cfg_we) tick_rate_r <= cfg_wdata;
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_kind == KIND_SET) begin
              for (int i = 0; i < ACT; i++) goal_r[i] <= tgt[i];
              rate_r  <= in_max_rate;
              maxd_r  <= '0;
              m_r     <= '0;
              state_r <= S_MAX;
            end else begin
              state_r <= S_TICK;
            end
          end
        end
        S_MAX: begin
          if (dcur > maxd_r) maxd_r <= dcur;
          if (m_r == LAST) begin
            m_r     <= '0;
            state_r <= S_MUL;
          end else begin
            m_r <= m_r + 1'b1;
          end
        end
        S_MUL: begin
          if (dcur == '0 || rate_r == '0) begin
            interval_r[mi] <= (dcur == '0) ? '0 : '1;
            if (m_r == LAST) begin
              state_r <= S_FIN;
            end else begin
              m_r <= m_r + 1'b1;
            end
          end else begin
            num_r   <= NUM_W'(tick_rate_r) * NUM_W'(maxd_r);
            den_r   <= DEN_W'(dcur) * DEN_W'(rate_r);
            state_r <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            interval_r[mi] <= (|div_quo[NUM_W-1:INT_W]) ? '1 : div_quo[INT_W-1:0];
            if (m_r == LAST) begin
              state_r <= S_FIN;
            end else begin
              m_r     <= m_r + 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_step_mask_r <= '0;
            out_dir_mask_r  <= dir_m;
            out_done_res_r  <= done_m;
            state_r         <= S_IDLE;
          end
        end
        S_TICK: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_step_mask_r <= step_m;
            out_dir_mask_r  <= dir_m;
            out_done_res_r  <= done_m;
            for (int i = 0; i < ACT; i++) begin
              if (step_m[i]) begin
                elapsed_r[i] <= '0;
                pos_r[i]     <= pos_nx[i];
              end else begin
                elapsed_r[i] <= el_inc[i];
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_step_mask = out_step_mask_r;
  assign out_dir_mask  = out_dir_mask_r;
  assign out_done_res  = out_done_res_r;

endmodule

`default_nettype wire

>>> src/csched_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. den_i must be nonzero.
module csched_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [csched_pkg::NUM_W-1:0]  num_i,
  input  logic [csched_pkg::DEN_W-1:0]  den_i,
  output logic                          done_o,
  output logic [csched_pkg::NUM_W-1:0]  quo_o
);

  import csched_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    // partial remainder always ends below den
    rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        rem_r  <= '0;
        den_r  <= den_i;
        quo_r  <= num_i;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

`default_nettype wire

>>> src/csched_checker.sv
`default_nettype none

module csched_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [csched_pkg::MASK_W-1:0]       out_step_mask,
  input logic [csched_pkg::MASK_W-1:0]       out_dir_mask,
  input logic                                out_done_res
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_mask)
      && $stable(out_dir_mask) && $stable(out_done_res))
    else $error("result word changed while stalled");

  // all motors at goal means nothing can step
  a_done_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_step_mask == '0)
    else $error("step reported with done set");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held across an accept");

  // no result can be produced in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind coordinated_stepper_scheduler csched_checker u_csched_checker (.*);

`default_nettype wire
